>>> design/size_class_pool_allocator_assert.svh
// Assertion macros shared by the pool allocator RTL.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SCPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scpa assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SCPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scpa assertion failed");

`endif

>>> design/scpa_pkg.sv
// Types, constants and class tables of the size class pool allocator.
package scpa_pkg;

  localparam int NUM_CLASSES = 7;
  localparam int WORD_BITS   = 64;
  localparam int MEM_WORDS   = 96;
  localparam int WADDR_W     = 7;
  localparam int BIT_W       = 6;
  localparam int FLAG_W      = 13;
  localparam int SLOT_W      = 11;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERSIZE  = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_SCOPE     = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_DOUBLE    = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_ADDR,
    S_FREE_SUB,
    S_FREE_DEC,
    S_FREE_CHK
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  function automatic logic [3:0] cls_shift(input logic [2:0] c);
    logic [3:0] r;
    case (c)
      3'd0:    r = 4'd4;
      3'd1:    r = 4'd5;
      3'd2:    r = 4'd6;
      3'd3:    r = 4'd7;
      3'd4:    r = 4'd8;
      3'd5:    r = 4'd9;
      3'd6:    r = 4'd10;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] cls_block(input logic [2:0] c);
    return 11'(1) << cls_shift(c);
  endfunction

  function automatic logic [11:0] cls_count(input logic [2:0] c);
    logic [11:0] r;
    case (c)
      3'd0:    r = 12'd2048;
      3'd1:    r = 12'd1024;
      3'd2:    r = 12'd512;
      3'd3:    r = 12'd1024;
      3'd4:    r = 12'd512;
      3'd5:    r = 12'd512;
      3'd6:    r = 12'd512;
      default: r = 12'd512;
    endcase
    return r;
  endfunction

  function automatic logic [19:0] cls_byte_start(input logic [2:0] c);
    logic [19:0] r;
    case (c)
      3'd0:    r = 20'd0;
      3'd1:    r = 20'd32768;
      3'd2:    r = 20'd65536;
      3'd3:    r = 20'd98304;
      3'd4:    r = 20'd229376;
      3'd5:    r = 20'd360448;
      3'd6:    r = 20'd622592;
      default: r = 20'd622592;
    endcase
    return r;
  endfunction

  function automatic logic [FLAG_W-1:0] cls_flag_start(input logic [2:0] c);
    logic [FLAG_W-1:0] r;
    case (c)
      3'd0:    r = 13'd0;
      3'd1:    r = 13'd2048;
      3'd2:    r = 13'd3072;
      3'd3:    r = 13'd3584;
      3'd4:    r = 13'd4608;
      3'd5:    r = 13'd5120;
      3'd6:    r = 13'd5632;
      default: r = 13'd5632;
    endcase
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] cls_word_start(input logic [2:0] c);
    logic [FLAG_W-1:0] f;
    f = cls_flag_start(c);
    return f[FLAG_W-1:BIT_W];
  endfunction

  function automatic logic [WADDR_W-1:0] cls_word_last(input logic [2:0] c);
    logic [11:0] n;
    n = cls_count(c);
    return WADDR_W'(cls_word_start(c) + WADDR_W'(n[11:BIT_W]) - WADDR_W'(1));
  endfunction

endpackage

>>> design/size_class_pool_allocator.sv
// Top level of the size class pool allocator: sequencer, register port and flag store.
//
// Allocate and free items are taken when start is high and busy is low; each gives
// exactly one result, shown for a single cycle with done high, which the receiver
// must take there and then. An allocate scans its class's flag words, one 64-bit
// word of the flag memory per cycle, from the class's first word until one holds a
// free slot or the class's last word has been checked, and then forms the address.
// An oversize request is answered straight from idle. A free subtracts the base (and
// ends there when the address lies below it), decodes class and slot (ending there
// when the slot is out of range), then checks the flag, clearing it when set. After
// reset the block clears all 96 words of the flag memory and holds busy high meanwhile.
module size_class_pool_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] request_size,
  input  logic [31:0] free_address,
  output logic        done,
  output logic [31:0] block_address,
  output logic [2:0]  status,
  output logic [2:0]  size_class
);

  `include "size_class_pool_allocator_assert.svh"

  scpa_pkg::state_t state, state_next;

  logic [31:0]                     base_address;
  logic [scpa_pkg::WADDR_W-1:0]    ptr, ptr_next;
  logic                            chk_valid, chk_valid_next;
  logic [scpa_pkg::WADDR_W-1:0]    chk_word, chk_word_next;
  logic [2:0]                      cls, cls_next;
  logic [31:0]                     req_addr, req_addr_next;
  logic [31:0]                     off, off_next;
  logic [scpa_pkg::SLOT_W-1:0]     slot, slot_next;
  logic [scpa_pkg::WADDR_W-1:0]    fword, fword_next;
  logic [scpa_pkg::BIT_W-1:0]      fbit, fbit_next;
  logic                            done_next;
  logic [31:0]                     block_address_next;
  logic [2:0]                      status_next, size_class_next;

  scpa_pkg::ram_wr_t               ram_wr;
  logic [scpa_pkg::WADDR_W-1:0]    raddr;
  logic [scpa_pkg::WORD_BITS-1:0]  rdata;
  scpa_pkg::alu_req_t              alu_req;
  logic [32:0]                     alu_result;
  logic                            zero_found;
  logic [scpa_pkg::BIT_W-1:0]      zero_index;

  logic                            accept;
  logic [2:0]                      alloc_cls;
  logic                            alloc_fit;
  logic [2:0]                      dec_cls;
  logic [31:0]                     dec_rel;
  logic [31:0]                     dec_idx;
  logic                            dec_in_range;
  logic [scpa_pkg::FLAG_W-1:0]     dec_flag;
  logic [scpa_pkg::WADDR_W-1:0]    scan_last;

  scpa_flag_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  scpa_first_zero u_find (
    .word  (rdata),
    .found (zero_found),
    .index (zero_index)
  );

  scpa_alu u_alu (
    .req    (alu_req),
    .result (alu_result)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? base_address : 32'd0;
  assign busy   = (state != scpa_pkg::S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 32'd0;
    end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
      base_address <= pwdata;
    end
  end

  // Smallest class that fits the request.
  always_comb begin
    alloc_cls = 3'd0;
    alloc_fit = 1'b0;
    for (int c = scpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if ({5'd0, scpa_pkg::cls_block(3'(c))} >= request_size) begin
        alloc_cls = 3'(c);
        alloc_fit = 1'b1;
      end
    end
  end

  // Class and slot of a free address from its offset.
  always_comb begin
    dec_cls = 3'd0;
    for (int c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
      if (off >= 32'(scpa_pkg::cls_byte_start(3'(c)))) begin
        dec_cls = 3'(c);
      end
    end
    dec_rel      = off - 32'(scpa_pkg::cls_byte_start(dec_cls));
    dec_idx      = dec_rel >> scpa_pkg::cls_shift(dec_cls);
    dec_in_range = dec_idx < 32'(scpa_pkg::cls_count(dec_cls));
    dec_flag     = scpa_pkg::cls_flag_start(dec_cls) + dec_idx[scpa_pkg::FLAG_W-1:0];
  end

  assign scan_last = scpa_pkg::cls_word_last(cls);

  always_comb begin
    state_next = state;
    case (state)
      scpa_pkg::S_CLEAR: begin
        if (ptr == scpa_pkg::WADDR_W'(scpa_pkg::MEM_WORDS - 1)) begin
          state_next = scpa_pkg::S_IDLE;
        end
      end
      scpa_pkg::S_IDLE: begin
        if (accept) begin
          if (action == scpa_pkg::ACT_FREE) begin
            state_next = scpa_pkg::S_FREE_SUB;
          end else if (alloc_fit) begin
            state_next = scpa_pkg::S_ALLOC_SCAN;
          end
        end
      end
      scpa_pkg::S_ALLOC_SCAN: begin
        if (chk_valid && zero_found) begin
          state_next = scpa_pkg::S_ALLOC_ADDR;
        end else if (chk_valid && chk_word == scan_last) begin
          state_next = scpa_pkg::S_IDLE;
        end
      end
      scpa_pkg::S_ALLOC_ADDR: state_next = scpa_pkg::S_IDLE;
      scpa_pkg::S_FREE_SUB: begin
        state_next = alu_result[32] ? scpa_pkg::S_IDLE : scpa_pkg::S_FREE_DEC;
      end
      scpa_pkg::S_FREE_DEC: begin
        state_next = dec_in_range ? scpa_pkg::S_FREE_CHK : scpa_pkg::S_IDLE;
      end
      scpa_pkg::S_FREE_CHK: state_next = scpa_pkg::S_IDLE;
      default: state_next = scpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ptr_next           = ptr;
    chk_valid_next     = 1'b0;
    chk_word_next      = ptr;
    cls_next           = cls;
    req_addr_next      = req_addr;
    off_next           = off;
    slot_next          = slot;
    fword_next         = fword;
    fbit_next          = fbit;
    done_next          = 1'b0;
    block_address_next = 32'd0;
    status_next        = status;
    size_class_next    = size_class;
    ram_wr             = '0;
    raddr              = ptr;
    alu_req            = '0;
    case (state)
      scpa_pkg::S_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = ptr;
        ram_wr.data = '0;
        ptr_next    = ptr + scpa_pkg::WADDR_W'(1);
      end
      scpa_pkg::S_IDLE: begin
        req_addr_next = free_address;
        cls_next      = alloc_cls;
        ptr_next      = scpa_pkg::cls_word_start(alloc_cls);
        if (accept && action == scpa_pkg::ACT_ALLOC && !alloc_fit) begin
          done_next       = 1'b1;
          status_next     = scpa_pkg::ST_OVERSIZE;
          size_class_next = 3'd0;
        end
      end
      scpa_pkg::S_ALLOC_SCAN: begin
        chk_valid_next = 1'b1;
        if (ptr != scan_last) begin
          ptr_next = ptr + scpa_pkg::WADDR_W'(1);
        end
        slot_next = {5'(chk_word - scpa_pkg::cls_word_start(cls)), zero_index};
        if (chk_valid && zero_found) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = chk_word;
          ram_wr.data = rdata | (scpa_pkg::WORD_BITS'(1) << zero_index);
        end else if (chk_valid && chk_word == scan_last) begin
          done_next       = 1'b1;
          status_next     = scpa_pkg::ST_EXHAUSTED;
          size_class_next = cls;
        end
      end
      scpa_pkg::S_ALLOC_ADDR: begin
        alu_req.a          = base_address;
        alu_req.b          = 32'(scpa_pkg::cls_byte_start(cls))
                             + (32'(slot) << scpa_pkg::cls_shift(cls));
        alu_req.sub        = 1'b0;
        done_next          = 1'b1;
        block_address_next = alu_result[31:0];
        status_next        = scpa_pkg::ST_OK;
        size_class_next    = cls;
      end
      scpa_pkg::S_FREE_SUB: begin
        alu_req.a   = req_addr;
        alu_req.b   = base_address;
        alu_req.sub = 1'b1;
        off_next    = alu_result[31:0];
        if (alu_result[32]) begin
          done_next       = 1'b1;
          status_next     = scpa_pkg::ST_SCOPE;
          size_class_next = 3'd0;
        end
      end
      scpa_pkg::S_FREE_DEC: begin
        raddr      = dec_flag[scpa_pkg::FLAG_W-1:scpa_pkg::BIT_W];
        fword_next = dec_flag[scpa_pkg::FLAG_W-1:scpa_pkg::BIT_W];
        fbit_next  = dec_flag[scpa_pkg::BIT_W-1:0];
        cls_next   = dec_cls;
        if (!dec_in_range) begin
          done_next       = 1'b1;
          status_next     = scpa_pkg::ST_RANGE;
          size_class_next = dec_cls;
        end
      end
      scpa_pkg::S_FREE_CHK: begin
        done_next       = 1'b1;
        size_class_next = cls;
        if (!rdata[fbit]) begin
          status_next = scpa_pkg::ST_DOUBLE;
        end else begin
          status_next = scpa_pkg::ST_OK;
          ram_wr.we   = 1'b1;
          ram_wr.addr = fword;
          ram_wr.data = rdata & ~(scpa_pkg::WORD_BITS'(1) << fbit);
        end
      end
      default: begin
        ptr_next = ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scpa_pkg::S_CLEAR;
      ptr       <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      chk_valid <= chk_valid_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_word      <= chk_word_next;
    cls           <= cls_next;
    req_addr      <= req_addr_next;
    off           <= off_next;
    slot          <= slot_next;
    fword         <= fword_next;
    fbit          <= fbit_next;
    block_address <= block_address_next;
    status        <= status_next;
    size_class    <= size_class_next;
  end

  `SCPA_ASSERT_NOW(a_fail_no_address, done && status != scpa_pkg::ST_OK, block_address == 32'd0)
  `SCPA_ASSERT_NOW(a_done_when_idle, done, state == scpa_pkg::S_IDLE)
  `SCPA_ASSERT_NEXT(a_exhausted_report,
    state == scpa_pkg::S_ALLOC_SCAN && chk_valid && !zero_found && chk_word == scan_last,
    done && status == scpa_pkg::ST_EXHAUSTED)

endmodule

>>> design/scpa_flag_ram.sv
// Slot use flag memory: 96 words of 64 flags, one write and one registered read port.
module scpa_flag_ram (
  input  logic                                       clk,
  input  scpa_pkg::ram_wr_t                          wr,
  input  logic [scpa_pkg::WADDR_W-1:0]               raddr,
  output logic [scpa_pkg::WORD_BITS-1:0]             rdata
);

  logic [scpa_pkg::WORD_BITS-1:0] mem [scpa_pkg::MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/scpa_first_zero.sv
// Finder for the lowest clear flag in one memory word.
module scpa_first_zero (
  input  logic [scpa_pkg::WORD_BITS-1:0] word,
  output logic                           found,
  output logic [scpa_pkg::BIT_W-1:0]     index
);

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = scpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        index = scpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

>>> design/scpa_alu.sv
// Shared 33-bit add and subtract unit for address arithmetic.
module scpa_alu (
  input  scpa_pkg::alu_req_t req,
  output logic [32:0]        result
);

  always_comb begin
    if (req.sub) begin
      result = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      result = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the size class pool allocator: directed and random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FLAG_SLOTS       = 6144;
  localparam logic [31:0] REGION_BYTES     = 32'd1146880;
  localparam logic [31:0] BASE_TOP         = 32'd4293820416;
  localparam logic [0:0]  REG_BASE_ADDRESS = 1'b0;

  localparam int BLK_SHIFT  [scpa_pkg::NUM_CLASSES] = '{4, 5, 6, 7, 8, 9, 10};
  localparam int SLOT_COUNT [scpa_pkg::NUM_CLASSES] = '{2048, 1024, 512, 1024, 512, 512, 512};
  localparam int BYTE_START [scpa_pkg::NUM_CLASSES] =
    '{0, 32768, 65536, 98304, 229376, 360448, 622592};
  localparam int FLAG_START [scpa_pkg::NUM_CLASSES] = '{0, 2048, 3072, 3584, 4608, 5120, 5632};

  typedef struct packed {
    logic [31:0] block_address;
    logic [2:0]  status;
    logic [2:0]  size_class;
  } pool_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic        action;
  logic [15:0] request_size;
  logic [31:0] free_address;
  logic        done;
  logic [31:0] block_address;
  logic [2:0]  status;
  logic [2:0]  size_class;

  logic [31:0]  base_model;
  bit           slot_used [FLAG_SLOTS];
  int           live_slots [$];
  pool_result_t pending_results [$];
  pool_result_t oldest_result;
  int           mismatch_count;

  size_class_pool_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .request_size  (request_size),
    .free_address  (free_address),
    .done          (done),
    .block_address (block_address),
    .status        (status),
    .size_class    (size_class)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int flag_class(input int flag);
    int c;
    c = 0;
    for (int k = 0; k < scpa_pkg::NUM_CLASSES; k++) begin
      if (flag >= FLAG_START[k]) c = k;
    end
    return c;
  endfunction

  function automatic logic [31:0] slot_address(input int flag);
    int c;
    c = flag_class(flag);
    return base_model + 32'(BYTE_START[c]) + 32'((flag - FLAG_START[c]) << BLK_SHIFT[c]);
  endfunction

  function automatic pool_result_t pool_predict(input logic act, input logic [15:0] size,
                                                input logic [31:0] addr);
    pool_result_t r;
    int           cls;
    int           flag;
    logic [31:0]  off;
    logic [31:0]  idx;
    r = '0;
    if (act == scpa_pkg::ACT_ALLOC) begin
      cls = -1;
      for (int c = scpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
        if ((32'd1 << BLK_SHIFT[c]) >= 32'(size)) cls = c;
      end
      if (cls < 0) begin
        r.status = scpa_pkg::ST_OVERSIZE;
        return r;
      end
      r.size_class = 3'(cls);
      r.status     = scpa_pkg::ST_EXHAUSTED;
      for (int i = 0; i < SLOT_COUNT[cls]; i++) begin
        flag = FLAG_START[cls] + i;
        if (!slot_used[flag]) begin
          slot_used[flag] = 1'b1;
          live_slots.push_back(flag);
          r.block_address = slot_address(flag);
          r.status        = scpa_pkg::ST_OK;
          break;
        end
      end
      return r;
    end
    if (addr < base_model) begin
      r.status = scpa_pkg::ST_SCOPE;
      return r;
    end
    off = addr - base_model;
    cls = 0;
    for (int c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
      if (off >= 32'(BYTE_START[c])) cls = c;
    end
    r.size_class = 3'(cls);
    idx = (off - 32'(BYTE_START[cls])) >> BLK_SHIFT[cls];
    if (idx >= 32'(SLOT_COUNT[cls])) begin
      r.status = scpa_pkg::ST_RANGE;
      return r;
    end
    flag = FLAG_START[cls] + int'(idx);
    if (!slot_used[flag]) begin
      r.status = scpa_pkg::ST_DOUBLE;
      return r;
    end
    slot_used[flag] = 1'b0;
    for (int j = 0; j < live_slots.size(); j++) begin
      if (live_slots[j] == flag) begin
        live_slots.delete(j);
        break;
      end
    end
    r.status = scpa_pkg::ST_OK;
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 32'd0, block_address);
      end else begin
        oldest_result = pending_results.pop_front();
        if (block_address !== oldest_result.block_address)
          flag_mismatch("block_address", oldest_result.block_address, block_address);
        if (status !== oldest_result.status)
          flag_mismatch("status", 32'(oldest_result.status), 32'(status));
        if (size_class !== oldest_result.size_class)
          flag_mismatch("size_class", 32'(oldest_result.size_class), 32'(size_class));
      end
    end
  end

  task automatic send_item(input logic act, input logic [15:0] size, input logic [31:0] addr);
    @(negedge clk);
    start        = 1'b1;
    action       = act;
    request_size = size;
    free_address = addr;
    do @(posedge clk); while (busy);
    pending_results.push_back(pool_predict(act, size, addr));
  endtask

  task automatic alloc_item(input logic [15:0] size);
    send_item(scpa_pkg::ACT_ALLOC, size, $urandom);
  endtask

  task automatic free_item(input logic [31:0] addr);
    send_item(scpa_pkg::ACT_FREE, 16'($urandom), addr);
  endtask

  task automatic maybe_pause(input bit pausing);
    int n;
    if (pausing && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    wait_drained();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_BASE_ADDRESS;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    base_model = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) flag_mismatch("base_address readback", value, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_alloc_sizes();
    int sizes [$];
    sizes = '{0, 1, 15, 16, 17, 32, 33, 64, 65, 128, 129, 256, 257, 512, 513, 1024,
              1025, 32768, 65535};
    write_base(32'd0);
    foreach (sizes[k]) alloc_item(16'(sizes[k]));
  endtask

  task automatic test_free_decode();
    logic [31:0] misaligned;
    write_base(32'h0010_0000);
    free_item(base_model - 32'd1);
    free_item(32'd0);
    free_item(base_model + REGION_BYTES);
    free_item(32'hFFFF_FFFF);
    misaligned = slot_address(FLAG_START[1] + 1) + 32'd7;
    free_item(misaligned);
    free_item(misaligned);
    free_item(slot_address(FLAG_START[3] + 100));
    free_item(slot_address(FLAG_START[0]));
    free_item(slot_address(FLAG_START[6]) + 32'd1023);
    alloc_item(16'd16);
    alloc_item(16'd20);
  endtask

  task automatic test_class_exhaustion();
    write_base(BASE_TOP);
    repeat (SLOT_COUNT[6] + 1) begin
      alloc_item(16'($urandom_range(513, 1024)));
      maybe_pause(1'b1);
    end
    free_item(32'hFFFF_FFFF);
    free_item(32'hFFFF_FFFF);
    alloc_item(16'd1024);
    alloc_item(16'd600);
    free_item(slot_address(FLAG_START[6] + 5) + 32'd3);
    alloc_item(16'd700);
  endtask

  task automatic test_random_traffic(input int n, input logic [31:0] base, input bit gaps);
    bit          pausing;
    int          pick;
    int          c;
    int          flag;
    logic [31:0] addr;
    logic [15:0] size;
    write_base(base);
    pausing = gaps;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) pausing = gaps && $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          7:       size = 16'(1 << $urandom_range(4, 10));
          8:       size = 16'($urandom_range(1025, 65535));
          9:       size = 16'($urandom);
          default: size = 16'($urandom_range(0, 1024));
        endcase
        alloc_item(size);
      end else if (pick < 80 && live_slots.size() != 0) begin
        flag = live_slots[$urandom_range(0, live_slots.size() - 1)];
        c    = flag_class(flag);
        addr = slot_address(flag);
        if ($urandom_range(0, 1)) addr += 32'($urandom_range(0, (1 << BLK_SHIFT[c]) - 1));
        free_item(addr);
      end else if (pick < 90) begin
        c    = $urandom_range(0, scpa_pkg::NUM_CLASSES - 1);
        addr = slot_address(FLAG_START[c] + $urandom_range(0, SLOT_COUNT[c] - 1));
        free_item(addr + 32'($urandom_range(0, (1 << BLK_SHIFT[c]) - 1)));
      end else begin
        case ($urandom_range(0, 3))
          0:       addr = base_model - 32'($urandom_range(1, 4096));
          1:       addr = base_model + REGION_BYTES + 32'($urandom_range(0, 4095));
          default: addr = $urandom;
        endcase
        free_item(addr);
      end
      maybe_pause(pausing);
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = REG_BASE_ADDRESS;
    pwdata         = 32'd0;
    start          = 1'b0;
    action         = scpa_pkg::ACT_ALLOC;
    request_size   = 16'd0;
    free_address   = 32'd0;
    base_model     = 32'd0;
    mismatch_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_alloc_sizes();
    test_free_decode();
    test_class_exhaustion();
    test_random_traffic(250, 32'd0, 1'b1);
    test_random_traffic(250, $urandom_range(0, BASE_TOP), 1'b1);
    test_random_traffic(250, BASE_TOP, 1'b1);
    test_random_traffic(250, $urandom_range(0, BASE_TOP), 1'b0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("size_class_pool_allocator: match");
    end else begin
      $display("size_class_pool_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("size_class_pool_allocator: mismatch");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/scpa_pkg.sv
design/scpa_flag_ram.sv
design/scpa_first_zero.sv
design/scpa_alu.sv
design/size_class_pool_allocator.sv
sim/tb_top.sv
